[design/cfc_pkg.sv]
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types, constants and the CRC-16 byte update for the frame checker.
// ----------------------------------------------------------------------------
package cfc_pkg;

  localparam int FRAME_LEN_DEF = 10;
  localparam int PAYLOAD_DEPTH = 8;
  localparam int PD_W          = $clog2(PAYLOAD_DEPTH);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QP_W          = $clog2(QUEUE_DEPTH);
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef logic [PAYLOAD_DEPTH-1:0][7:0] payload_t;

  // One finished frame handed from front to back.
  typedef struct packed {
    logic     nak;
    payload_t data;
  } frame_cmd_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ {4'd0, x[7:4]};
    return {crc[7:0], 8'd0} ^ {x[3:0], 12'd0} ^ {3'd0, x, 5'd0} ^ {8'd0, x};
  endfunction

endpackage

[design/cfc_front.sv]
// ----------------------------------------------------------------------------
// cfc_front
// Accepts frame bytes, runs the CRC, stores payload and pushes one command
// per completed frame.
// ----------------------------------------------------------------------------
module cfc_front #(
  parameter int FRAME_LEN = cfc_pkg::FRAME_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          rx_byte,
  input  logic                frame_start,
  input  logic                q_full,
  output logic                in_ready,
  output logic                push,
  output cfc_pkg::frame_cmd_t push_cmd
);
  import cfc_pkg::*;

  localparam int POS_W = $clog2(FRAME_LEN);
  localparam logic [POS_W-1:0] TRAILER_POS = POS_W'(FRAME_LEN - 1);

  logic [POS_W-1:0] position;
  logic [15:0]      crc;
  payload_t         store;

  logic             accept;
  logic [POS_W-1:0] pos_eff;
  logic [15:0]      crc_eff;
  logic [6:0]       pos_ext;
  logic             is_trailer;
  logic             is_payload;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign pos_eff    = frame_start ? '0 : position;
  assign crc_eff    = frame_start ? CRC_INIT : crc;
  assign pos_ext    = 7'(pos_eff);
  assign is_trailer = (pos_eff == TRAILER_POS);
  assign is_payload = (pos_ext >= 7'd1) && (pos_ext <= 7'(PAYLOAD_DEPTH));

  assign push          = accept && is_trailer;
  assign push_cmd.nak  = (rx_byte != crc_eff[7:0]);
  assign push_cmd.data = store;

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      crc      <= CRC_INIT;
    end else if (accept) begin
      if (is_trailer) begin
        position <= '0;
        crc      <= CRC_INIT;
      end else begin
        position <= pos_eff + 1'b1;
        crc      <= crc_update(crc_eff, rx_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_trailer && is_payload) begin
      store[PD_W'(pos_ext - 7'd1)] <= rx_byte;
    end
  end

endmodule

[design/cfc_queue.sv]
// ----------------------------------------------------------------------------
// cfc_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module cfc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cfc_pkg::frame_cmd_t push_cmd,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output cfc_pkg::frame_cmd_t head
);
  import cfc_pkg::*;

  frame_cmd_t           entries [QUEUE_DEPTH];
  logic [QP_W-1:0]      wr_ptr;
  logic [QP_W-1:0]      rd_ptr;
  logic [QP_W:0]        count;

  assign full  = (count == (QP_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

[design/cfc_back.sv]
// ----------------------------------------------------------------------------
// cfc_back
// Drains queued frame commands into result transactions through an output
// register.
// ----------------------------------------------------------------------------
module cfc_back #(
  parameter int FRAME_LEN = cfc_pkg::FRAME_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  cfc_pkg::frame_cmd_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          payload_byte,
  output logic                kind,
  output logic                last
);
  import cfc_pkg::*;

  localparam int CNT = (FRAME_LEN - 2 < PAYLOAD_DEPTH) ? FRAME_LEN - 2 : PAYLOAD_DEPTH;
  localparam logic [PD_W-1:0] LAST_IDX = PD_W'(CNT - 1);

  logic [PD_W-1:0] idx;
  logic            load;
  logic            emit;
  logic            at_last;

  assign load    = !out_valid || out_ready;
  assign emit    = load && !q_empty;
  assign at_last = head.nak || (idx == LAST_IDX);
  assign pop     = emit && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (emit) begin
      out_valid <= 1'b1;
      idx       <= at_last ? '0 : idx + 1'b1;
    end else if (load) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind         <= head.nak;
      payload_byte <= head.nak ? 8'd0 : head.data[idx];
      last         <= at_last;
    end
  end

endmodule

[design/crc16_frame_checker_core.sv]
// ----------------------------------------------------------------------------
// crc16_frame_checker_core
// Fixed-length frame receiver, CRC-16 low-byte trailer check, payload release.
// ----------------------------------------------------------------------------
// channel | direction | tdata          | tuser       | tlast
// s_*     | in        | rx_byte        | frame_start | -
// m_*     | out       | payload_byte   | kind        | last
//
// One byte accepted per cycle while the frame queue is not full; the CRC
// update is a table-free nibble step in the front part.
// A matching frame yields up to eight result transactions, one per cycle
// while m_tready is high, drained by the back from a two-entry frame queue.
// s_tready drops only while the frame queue is full.
// Synchronous reset clears position, CRC, queue pointers and output valid.
// ----------------------------------------------------------------------------
module crc16_frame_checker_core #(
  parameter int FRAME_LEN = cfc_pkg::FRAME_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic       s_tuser,   // [0] frame_start
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] payload_byte
  output logic       m_tuser,   // [0] kind
  output logic       m_tlast
);
  import cfc_pkg::*;

  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  frame_cmd_t push_cmd;
  frame_cmd_t head;

  cfc_front #(.FRAME_LEN(FRAME_LEN)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .rx_byte     (s_tdata),
    .frame_start (s_tuser),
    .q_full      (q_full),
    .in_ready    (s_tready),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  cfc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  cfc_back #(.FRAME_LEN(FRAME_LEN)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .payload_byte (m_tdata),
    .kind         (m_tuser),
    .last         (m_tlast)
  );

endmodule

[design/cfc_checker.sv]
// ----------------------------------------------------------------------------
// cfc_checker
// Port-level assertions for the frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module cfc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser,
  input logic       m_tlast
);

  a_nak_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
    else $error("negative acknowledge not a lone zero transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  a_rst_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("input not ready after reset");

endmodule

bind crc16_frame_checker_core cfc_checker u_cfc_checker (.*);
